// ----- sv/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg: shared constants and tables for the calendar time converter
// reciprocal constants, month start days and month abbreviations
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int unsigned IN_W       = 25;
   localparam int unsigned DAY_W      = 9;   // day of year, up to 388 for 25-bit counts
   localparam int unsigned REM_DAY_W  = 17;  // seconds within a day
   localparam int unsigned REM_HOUR_W = 12;  // seconds within an hour
   localparam int unsigned MON_W      = 4;
   localparam int unsigned STAGES     = 6;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 56;

   // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
   localparam logic [18:0] DAY_RECIP  = 19'd397683;  // ceil(2^28 / 675)
   localparam logic [13:0] HOUR_RECIP = 14'd9321;    // ceil(2^21 / 225)
   localparam logic [10:0] MIN_RECIP  = 11'd1093;    // ceil(2^14 / 15)

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;

   // first day of year of each month, index 0 is january
   function automatic logic [DAY_W-1:0] month_start(input logic [MON_W-1:0] idx);
      logic [DAY_W-1:0] d;
      case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // abbreviation with the first letter in the top byte
   function automatic logic [23:0] month_text(input logic [MON_W-1:0] idx);
      logic [23:0] t;
      case (idx)
         4'd0:    t = "JAN";
         4'd1:    t = "FEB";
         4'd2:    t = "MAR";
         4'd3:    t = "APR";
         4'd4:    t = "MAY";
         4'd5:    t = "JUN";
         4'd6:    t = "JUL";
         4'd7:    t = "AUG";
         4'd8:    t = "SEP";
         4'd9:    t = "OCT";
         4'd10:   t = "NOV";
         4'd11:   t = "DEC";
         default: t = 24'd0;
      endcase
      return t;
   endfunction

endpackage

// ----- sv/sct_month_find.sv -----
// ----------------------------------------------------------------------------
// sct_month_find: month lookup
// turns a day of year into a month index 0..11 by parallel boundary compares
// ----------------------------------------------------------------------------
module sct_month_find
   import sct_pkg::*;
(
   input  logic [DAY_W-1:0] day_index,
   output logic [MON_W-1:0] month_index
);

   logic [10:0] past_start;

   // one compare per month boundary, the count of boundaries passed is the month
   always_comb begin
      for (int k = 0; k < 11; k++) begin
         past_start[k] = (day_index >= month_start(MON_W'(k + 1)));
      end
      month_index = MON_W'($countones(past_start));
   end

endmodule

// ----- sv/seconds_to_calendar_time.sv -----
// ----------------------------------------------------------------------------
// seconds_to_calendar_time: seconds of year to month, day and time of day
// six stage pipeline converting a non-leap year second count to calendar form
// ----------------------------------------------------------------------------
// usage
//   req channel carries one 25-bit second count per request in req_tdata
//   rsp channel returns month, day, hour, minute, second and the three ascii
//   letters of the month in rsp_tdata, with the out-of-range flag in rsp_tuser
//   the accepting edge loads stage one; the request then moves through the stages
//   in turn, and rsp_tvalid rises once it reaches the result register, where it can be taken
//   throughput is one request per cycle unless a low rsp_tready stalls the full pipe;
//   each of the six stages holds one request and has at most one constant multiply
//   the day, hour and minute divisions are reciprocal multiplies, the month
//   comes from eleven parallel compares against the month start table
//   counts of 365 days or more set rsp_tuser and zero all of rsp_tdata
//   reset clears the stage valid bits only; the pipe is empty afterwards
//   when rsp_tready is low, the result holds and stages behind it keep filling
//   until each holds a request; req_tready drops only when the pipe is full
// ----------------------------------------------------------------------------
module seconds_to_calendar_time
   import sct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [24:0] seconds_of_year

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] month_number, [8:4] day_of_month,
                                              // [13:9] hour_value, [19:14] minute_value,
                                              // [25:20] second_value,
                                              // [33:26] month_letter_first,
                                              // [41:34] month_letter_second,
                                              // [49:42] month_letter_third
   output logic                  rsp_tuser    // [0] out_of_range
);

   // per stage valid bits and advance enables
   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES-1:0] rdy;

   // stage 1: day index by reciprocal multiply
   logic [IN_W-1:0]      s1_secs_ff, s1_secs_in;
   logic [DAY_W-1:0]     s1_day_ff, s1_day_in;
   logic [36:0]          s1_prod;

   // stage 2: seconds within the day, range check, month index
   logic [REM_DAY_W-1:0] s2_rem_ff, s2_rem_in;
   logic [DAY_W-1:0]     s2_day_ff, s2_day_in;
   logic [MON_W-1:0]     s2_mon_ff, s2_mon_in;
   logic                 s2_oor_ff, s2_oor_in;
   logic [25:0]          s2_day_secs;
   logic [MON_W-1:0]     s2_mon_found;

   // stage 3: hour, day of month
   logic [REM_DAY_W-1:0] s3_rem_ff, s3_rem_in;
   logic [4:0]           s3_hour_ff, s3_hour_in;
   logic [4:0]           s3_mday_ff, s3_mday_in;
   logic [MON_W-1:0]     s3_mon_ff, s3_mon_in;
   logic                 s3_oor_ff, s3_oor_in;
   logic [26:0]          s3_prod;
   logic [DAY_W-1:0]     s3_mday_full;

   // stage 4: seconds within the hour
   logic [REM_HOUR_W-1:0] s4_rem_ff, s4_rem_in;
   logic [4:0]            s4_hour_ff;
   logic [4:0]            s4_mday_ff;
   logic [MON_W-1:0]      s4_mon_ff;
   logic                  s4_oor_ff;
   logic [16:0]           s4_hour_secs;
   logic [REM_DAY_W-1:0]  s4_rem_full;

   // stage 5: minute
   logic [REM_HOUR_W-1:0] s5_rem_ff;
   logic [5:0]            s5_min_ff, s5_min_in;
   logic [4:0]            s5_hour_ff;
   logic [4:0]            s5_mday_ff;
   logic [MON_W-1:0]      s5_mon_ff;
   logic                  s5_oor_ff;
   logic [20:0]           s5_prod;

   // stage 6: second and result register
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_oor_ff;
   logic [11:0]           s6_min_secs;
   logic [REM_HOUR_W-1:0] s6_sec_full;
   logic [23:0]           s6_text;

   // ready ripples back: a stage moves when it is empty or the next one moves
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   assign req_tready = rdy[0];

   // stage 1 datapath
   always_comb begin
      s1_secs_in = req_tdata[IN_W-1:0];
      s1_prod    = 37'(req_tdata[IN_W-1:7]) * 37'(DAY_RECIP);
      s1_day_in  = s1_prod[36:28];
   end

   // stage 2 datapath
   sct_month_find u_month_find (
      .day_index   (s1_day_ff),
      .month_index (s2_mon_found)
   );

   always_comb begin
      s2_day_secs = 26'(s1_day_ff) * 26'(SECS_PER_DAY);
      s2_rem_in   = REM_DAY_W'(26'(s1_secs_ff) - s2_day_secs);
      s2_day_in   = s1_day_ff;
      s2_mon_in   = s2_mon_found;
      s2_oor_in   = (s1_day_ff >= DAYS_PER_YEAR);
   end

   // stage 3 datapath
   always_comb begin
      s3_prod      = 27'(s2_rem_ff[REM_DAY_W-1:4]) * 27'(HOUR_RECIP);
      s3_hour_in   = s3_prod[25:21];
      s3_mday_full = s2_day_ff - month_start(s2_mon_ff) + DAY_W'(1);
      s3_mday_in   = s3_mday_full[4:0];
      s3_rem_in    = s2_rem_ff;
      s3_mon_in    = s2_mon_ff;
      s3_oor_in    = s2_oor_ff;
   end

   // stage 4 datapath
   always_comb begin
      s4_hour_secs = 17'(s3_hour_ff) * 17'(SECS_PER_HOUR);
      s4_rem_full  = s3_rem_ff - s4_hour_secs;
      s4_rem_in    = s4_rem_full[REM_HOUR_W-1:0];
   end

   // stage 5 datapath
   always_comb begin
      s5_prod   = 21'(s4_rem_ff[REM_HOUR_W-1:2]) * 21'(MIN_RECIP);
      s5_min_in = s5_prod[19:14];
   end

   // stage 6: second, letters, zeroing past year end
   always_comb begin
      s6_min_secs = 12'(s5_min_ff) * 12'(SECS_PER_MIN);
      s6_sec_full = s5_rem_ff - s6_min_secs;
      s6_text     = month_text(s5_mon_ff);
      rsp_data_in = '0;
      if (!s5_oor_ff) begin
         rsp_data_in[3:0]   = s5_mon_ff + MON_W'(1);
         rsp_data_in[8:4]   = s5_mday_ff;
         rsp_data_in[13:9]  = s5_hour_ff;
         rsp_data_in[19:14] = s5_min_ff;
         rsp_data_in[25:20] = s6_sec_full[5:0];
         rsp_data_in[33:26] = s6_text[23:16];
         rsp_data_in[41:34] = s6_text[15:8];
         rsp_data_in[49:42] = s6_text[7:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload registers, loaded when their stage moves
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_secs_ff <= s1_secs_in;
         s1_day_ff  <= s1_day_in;
      end
      if (rdy[1]) begin
         s2_rem_ff <= s2_rem_in;
         s2_day_ff <= s2_day_in;
         s2_mon_ff <= s2_mon_in;
         s2_oor_ff <= s2_oor_in;
      end
      if (rdy[2]) begin
         s3_rem_ff  <= s3_rem_in;
         s3_hour_ff <= s3_hour_in;
         s3_mday_ff <= s3_mday_in;
         s3_mon_ff  <= s3_mon_in;
         s3_oor_ff  <= s3_oor_in;
      end
      if (rdy[3]) begin
         s4_rem_ff  <= s4_rem_in;
         s4_hour_ff <= s3_hour_ff;
         s4_mday_ff <= s3_mday_ff;
         s4_mon_ff  <= s3_mon_ff;
         s4_oor_ff  <= s3_oor_ff;
      end
      if (rdy[4]) begin
         s5_rem_ff  <= s4_rem_ff;
         s5_min_ff  <= s5_min_in;
         s5_hour_ff <= s4_hour_ff;
         s5_mday_ff <= s4_mday_ff;
         s5_mon_ff  <= s4_mon_ff;
         s5_oor_ff  <= s4_oor_ff;
      end
      if (rdy[5]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_oor_ff  <= s5_oor_ff;
      end
   end

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

   // an empty output register means the whole pipe can move
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with an empty result register");

   // past year end every calendar field is zero
   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("out-of-range result carries nonzero fields");

   // in range results stay within calendar limits
   a_fields_in_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tdata[3:0] != 4'd0) && (rsp_tdata[3:0] <= 4'd12) &&
         (rsp_tdata[8:4] != 5'd0) && (rsp_tdata[13:9] < 5'd24) &&
         (rsp_tdata[19:14] < 6'd60) && (rsp_tdata[25:20] < 6'd60))
      else $error("calendar field out of its range");

endmodule

// ----- sim/seconds_to_calendar_time_tb.sv -----
// ----------------------------------------------------------------------------
// seconds_to_calendar_time_tb: self-checking bench for the calendar converter
// streams second counts through the block, predicts month, day, time of day
// and month letters per request, and checks every response in order while
// both sides idle and stall in turn
// ----------------------------------------------------------------------------
module seconds_to_calendar_time_tb
   import sct_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned HOUR_SECONDS   = 3600;
   localparam int unsigned MINUTE_SECONDS = 60;
   localparam int unsigned DAYS_IN_YEAR   = 365;
   localparam int unsigned YEAR_SECONDS   = DAYS_IN_YEAR * DAY_SECONDS;
   localparam int unsigned MAX_SECONDS    = (1 << IN_W) - 1;

   localparam int unsigned RANDOM_PER_PHASE = 350;
   localparam int unsigned BACKLOG_REQUESTS = 60;
   localparam int unsigned HOLD_CYCLES      = 300;   // receiver holds off this long
   localparam int unsigned TAIL_CYCLES      = 20;    // well past the time a request takes through the pipe
   localparam int unsigned WATCHDOG_LIMIT   = 2000;

   // day of year on which each month begins, january first
   localparam int unsigned FIRST_DAY [12] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
   };

   // month abbreviations, first letter in the top byte
   localparam logic [23:0] MONTH_ABBREV [12] = '{
      "JAN", "FEB", "MAR", "APR", "MAY", "JUN",
      "JUL", "AUG", "SEP", "OCT", "NOV", "DEC"
   };

   typedef enum int {
      PH_DIRECTED,
      PH_STREAM,
      PH_SENDER_GAPS,
      PH_RECEIVER_STALLS,
      PH_BOTH_IDLE,
      PH_BACKLOG
   } phase_type;

   typedef struct packed {
      logic [3:0] month_number;
      logic [4:0] day_of_month;
      logic [4:0] hour_value;
      logic [5:0] minute_value;
      logic [5:0] second_value;
      logic [7:0] month_letter_first;
      logic [7:0] month_letter_second;
      logic [7:0] month_letter_third;
      logic       out_of_range;
   } calendar_type;

   // block ports, every input known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [24:0] seconds_of_year
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [3:0] month, [8:4] day, [13:9] hour,
                                              // [19:14] minute, [25:20] second,
                                              // [33:26] first, [41:34] second,
                                              // [49:42] third letter
   logic                  rsp_tuser;          // [0] out_of_range

   // stimulus and scoreboard state
   logic [IN_W-1:0] pending_seconds [$];     // counts waiting to be offered
   calendar_type    expected_calendar [$];   // predictions awaiting a response

   phase_type   phase              = PH_DIRECTED;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_count         = 0;
   int unsigned quiet_cycles       = 0;

   int unsigned error_count     = 0;
   int unsigned request_count   = 0;
   int unsigned past_year_count = 0;
   int unsigned response_count  = 0;
   int unsigned input_stalls    = 0;

   seconds_to_calendar_time dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expected calendar form of a second count; counts past the year end give
   // only the flag with every other field zero
   function automatic calendar_type calendar_of(input logic [IN_W-1:0] secs);
      calendar_type cal;
      int unsigned  day;
      int unsigned  rest;
      int unsigned  mon;
      cal = '0;
      day = secs / DAY_SECONDS;
      if (day >= DAYS_IN_YEAR) begin
         cal.out_of_range = 1'b1;
         return cal;
      end
      rest             = secs % DAY_SECONDS;
      cal.hour_value   = 5'(rest / HOUR_SECONDS);
      cal.minute_value = 6'((rest % HOUR_SECONDS) / MINUTE_SECONDS);
      cal.second_value = 6'(rest % MINUTE_SECONDS);
      // last month whose first day is not after the day of year
      mon = 11;
      while (mon > 0 && day < FIRST_DAY[mon])
         mon--;
      cal.month_number = 4'(mon + 1);
      cal.day_of_month = 5'(day - FIRST_DAY[mon] + 1);
      {cal.month_letter_first, cal.month_letter_second, cal.month_letter_third} =
         MONTH_ABBREV[mon];
      return cal;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // driver: records each accepted request with its prediction, then offers
   // the next count unless the sender idles; valid holds until accepted
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_calendar.push_back(calendar_of(req_tdata[IN_W-1:0]));
            request_count++;
            if (req_tdata[IN_W-1:0] >= YEAR_SECONDS)
               past_year_count++;
         end
         if (req_tvalid && !req_tready)
            input_stalls++;
         if (!req_tvalid || req_tready) begin
            offer = pending_seconds.size() > 0 && $urandom_range(99) >= sender_idle_pct;
            if (offer) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'(pending_seconds.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls per phase; in the backlog phase it first holds
   // off for a long stretch so the pipe fills and the input stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (phase == PH_BACKLOG && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= receiver_stall_pct;
      end
   end

   // monitor: each response against the oldest outstanding prediction
   always @(posedge clock) begin
      calendar_type got;
      calendar_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.month_number        = rsp_tdata[3:0];
         got.day_of_month        = rsp_tdata[8:4];
         got.hour_value          = rsp_tdata[13:9];
         got.minute_value        = rsp_tdata[19:14];
         got.second_value        = rsp_tdata[25:20];
         got.month_letter_first  = rsp_tdata[33:26];
         got.month_letter_second = rsp_tdata[41:34];
         got.month_letter_third  = rsp_tdata[49:42];
         got.out_of_range        = rsp_tuser;
         response_count++;
         if (expected_calendar.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_calendar.pop_front();
            check_field("month_number", want.month_number, got.month_number);
            check_field("day_of_month", want.day_of_month, got.day_of_month);
            check_field("hour_value", want.hour_value, got.hour_value);
            check_field("minute_value", want.minute_value, got.minute_value);
            check_field("second_value", want.second_value, got.second_value);
            check_field("month_letter_first", want.month_letter_first,
                        got.month_letter_first);
            check_field("month_letter_second", want.month_letter_second,
                        got.month_letter_second);
            check_field("month_letter_third", want.month_letter_third,
                        got.month_letter_third);
            check_field("out_of_range", want.out_of_range, got.out_of_range);
         end
      end
   end

   // watchdog: too long with no request and no response accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL seconds_to_calendar_time");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sender stops once its queue runs dry and waits until every response
   // is back, so the next phase starts on an empty pipe
   task automatic drain;
      while (pending_seconds.size() > 0 || req_tvalid)
         @(negedge clock);
      while (expected_calendar.size() > 0)
         @(negedge clock);
   endtask

   // random counts: mostly inside the year, plus month and year-end
   // boundaries, counts past the year end and raw 25-bit patterns
   task automatic queue_random(input int unsigned count);
      int unsigned pick;
      int unsigned mon;
      int unsigned edge_secs;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            pending_seconds.push_back(IN_W'($urandom_range(YEAR_SECONDS - 1)));
         end else if (pick < 80) begin
            // either side of a month start, twelve meaning the year end
            mon       = $urandom_range(12);
            edge_secs = (mon == 12) ? YEAR_SECONDS : FIRST_DAY[mon] * DAY_SECONDS;
            if (edge_secs == 0)
               pending_seconds.push_back(IN_W'($urandom_range(1)));
            else
               pending_seconds.push_back(IN_W'(edge_secs - 1 + $urandom_range(1)));
         end else if (pick < 90) begin
            pending_seconds.push_back(IN_W'($urandom_range(MAX_SECONDS, YEAR_SECONDS)));
         end else begin
            pending_seconds.push_back(IN_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: start of year, ends of minute, hour and day, every month
      // start, end of january, last second of the year, first count past it,
      // the largest count and alternating bit patterns
      phase = PH_DIRECTED;
      pending_seconds.push_back(IN_W'(0));
      pending_seconds.push_back(IN_W'(59));
      pending_seconds.push_back(IN_W'(3599));
      pending_seconds.push_back(IN_W'(86399));
      pending_seconds.push_back(IN_W'(86400));
      for (int m = 1; m < 12; m++)
         pending_seconds.push_back(IN_W'(FIRST_DAY[m] * DAY_SECONDS));
      pending_seconds.push_back(IN_W'(31 * DAY_SECONDS - 1));
      pending_seconds.push_back(IN_W'(YEAR_SECONDS - 1));
      pending_seconds.push_back(IN_W'(YEAR_SECONDS));
      pending_seconds.push_back(IN_W'(MAX_SECONDS));
      pending_seconds.push_back(IN_W'(25'h1555555));
      pending_seconds.push_back(IN_W'(25'h0AAAAAA));
      drain();

      // random traffic under each idling mix
      phase = PH_STREAM;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      queue_random(RANDOM_PER_PHASE);
      drain();

      phase = PH_SENDER_GAPS;
      sender_idle_pct    = 61;
      receiver_stall_pct = 0;
      queue_random(RANDOM_PER_PHASE);
      drain();

      phase = PH_RECEIVER_STALLS;
      sender_idle_pct    = 0;
      receiver_stall_pct = 61;
      queue_random(RANDOM_PER_PHASE);
      drain();

      phase = PH_BOTH_IDLE;
      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      queue_random(RANDOM_PER_PHASE);
      drain();

      // backlog: receiver holds off while the sender keeps offering
      phase = PH_BACKLOG;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      queue_random(BACKLOG_REQUESTS);
      while (hold_count < HOLD_CYCLES)
         @(negedge clock);
      drain();

      // let any stray response show up before judging
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_calendar.size() > 0) begin
         $error("%0d responses never arrived", expected_calendar.size());
         error_count++;
      end

      $display("run covered %0d requests (%0d past the year end), %0d responses checked",
               request_count, past_year_count, response_count);
      $display("input held back for %0d cycles under receiver backpressure", input_stalls);
      if (error_count == 0) begin
         $display("PASS seconds_to_calendar_time");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL seconds_to_calendar_time");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/sct_pkg.sv
sv/sct_month_find.sv
sv/seconds_to_calendar_time.sv
sim/seconds_to_calendar_time_tb.sv
